@@ rtl/nec_chk_pkg.sv @@
// ----------------------------------------------------------------------------
// nec_chk_pkg
// Shared types and constants of the NEC infrared frame checker.
// ----------------------------------------------------------------------------
package nec_chk_pkg;

  localparam int unsigned DurW   = 16;
  localparam int unsigned SumW   = 17;
  localparam int unsigned CodeW  = 32;
  localparam int unsigned PosW   = 7;
  localparam int unsigned BitCntW = 6;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [DurW-1:0] LeadMarkMin  = 16'd8500;
  localparam logic [DurW-1:0] LeadMarkMax  = 16'd9500;
  localparam logic [DurW-1:0] LeadSpaceMin = 16'd4000;
  localparam logic [DurW-1:0] LeadSpaceMax = 16'd5000;
  localparam logic [BitCntW-1:0] CodeBitsTotal = 6'd32;
  localparam logic [PosW-1:0]    PosMax        = 7'd127;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StLeader   = 3'd1,
    StTiming   = 3'd2,
    StShort    = 3'd3,
    StMismatch = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegExpectedCode = 3'd0,
    RegZeroSumLow   = 3'd1,
    RegZeroSumHigh  = 3'd2,
    RegOneSumLow    = 3'd3,
    RegOneSumHigh   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [CodeW-1:0] expected_code;
    logic [SumW-1:0]  zero_sum_low;
    logic [SumW-1:0]  zero_sum_high;
    logic [SumW-1:0]  one_sum_low;
    logic [SumW-1:0]  one_sum_high;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    expected_code: 32'd3208659008,
    zero_sum_low:  17'd680,
    zero_sum_high: 17'd1560,
    one_sum_low:   17'd1800,
    one_sum_high:  17'd2680
  };

endpackage

@@ rtl/nec_chk_cfg.sv @@
// ----------------------------------------------------------------------------
// nec_chk_cfg
// Configuration register file: expected code and bit timing windows.
// ----------------------------------------------------------------------------
module nec_chk_cfg
  import nec_chk_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CodeW-1:0]   cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_valid_i) begin
      // indexes beyond the register list are dropped
      unique case (cfg_index_i)
        RegExpectedCode: cfg_q.expected_code <= cfg_data_i;
        RegZeroSumLow:   cfg_q.zero_sum_low  <= cfg_data_i[SumW-1:0];
        RegZeroSumHigh:  cfg_q.zero_sum_high <= cfg_data_i[SumW-1:0];
        RegOneSumLow:    cfg_q.one_sum_low   <= cfg_data_i[SumW-1:0];
        RegOneSumHigh:   cfg_q.one_sum_high  <= cfg_data_i[SumW-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/nec_chk_core.sv @@
// ----------------------------------------------------------------------------
// nec_chk_core
// Frame state and per-duration decode: leader checks, pair classification,
// bit assembly and end-of-frame status.
// ----------------------------------------------------------------------------
module nec_chk_core
  import nec_chk_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [DurW-1:0]  duration_i,
  input  logic             frame_end_i,
  input  cfg_t             cfg_i,
  output status_e          status_o,
  output logic [CodeW-1:0] code_o
);

  logic [PosW-1:0]    pos_q, pos_d;
  logic [DurW-1:0]    mark_q, mark_d;
  logic [CodeW-1:0]   code_q, code_d;
  logic [BitCntW-1:0] bits_q, bits_d;
  status_e            err_q, err_d;
  logic               stop_q, stop_d;

  logic [DurW-1:0] lead_lo, lead_hi, lead_dur;
  logic            lead_bad, lead_space_missing;
  logic [DurW-1:0] pair_mark, pair_space;
  logic [SumW-1:0] sum;
  logic            is_zero, is_one, do_pair;

  always_comb begin
    // leader bounds by position: mark at 0, space at 1
    lead_dur = duration_i;
    if (pos_q == '0) begin
      lead_lo = LeadMarkMin;
      lead_hi = LeadMarkMax;
    end else begin
      lead_lo = LeadSpaceMin;
      lead_hi = LeadSpaceMax;
    end
    lead_bad = (lead_dur < lead_lo) || (lead_dur > lead_hi);
    // a frame ending on the leader mark has a zero-length space, always bad
    lead_space_missing = (pos_q == '0) && frame_end_i;

    if (!pos_q[0]) begin
      pair_mark  = duration_i;
      pair_space = '0;
    end else begin
      pair_mark  = mark_q;
      pair_space = duration_i;
    end
    sum     = {1'b0, pair_mark} + {1'b0, pair_space};
    is_zero = (sum > cfg_i.zero_sum_low) && (sum < cfg_i.zero_sum_high);
    is_one  = (sum > cfg_i.one_sum_low) && (sum < cfg_i.one_sum_high);
    do_pair = (pos_q > 7'd1) && (pos_q[0] || frame_end_i);
  end

  always_comb begin
    pos_d  = pos_q;
    mark_d = mark_q;
    code_d = code_q;
    bits_d = bits_q;
    err_d  = err_q;
    stop_d = stop_q;

    if (pos_q < 7'd2) begin
      if (err_q == StOk && (lead_bad || lead_space_missing)) begin
        err_d = StLeader;
      end
    end else begin
      if (!pos_q[0]) begin
        mark_d = duration_i;
      end
      if (do_pair && err_q == StOk && !stop_q) begin
        if (bits_q >= CodeBitsTotal) begin
          if (!is_zero && !is_one) begin
            stop_d = 1'b1;
          end
        end else if (is_zero) begin
          bits_d = bits_q + 6'd1;
        end else if (is_one) begin
          code_d = code_q | (CodeW'(1) << bits_q[4:0]);
          bits_d = bits_q + 6'd1;
        end else begin
          err_d = StTiming;
        end
      end
    end

    if (pos_q < PosMax) begin
      pos_d = pos_q + 7'd1;
    end

    // end-of-frame result, from the state after this duration
    code_o = code_d;
    priority if (err_d != StOk) begin
      status_o = err_d;
    end else if (bits_d < CodeBitsTotal) begin
      status_o = StShort;
    end else if (code_d != cfg_i.expected_code) begin
      status_o = StMismatch;
    end else begin
      status_o = StOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      mark_q <= '0;
      code_q <= '0;
      bits_q <= '0;
      err_q  <= StOk;
      stop_q <= 1'b0;
    end else if (step_i) begin
      if (frame_end_i) begin
        pos_q  <= '0;
        mark_q <= '0;
        code_q <= '0;
        bits_q <= '0;
        err_q  <= StOk;
        stop_q <= 1'b0;
      end else begin
        pos_q  <= pos_d;
        mark_q <= mark_d;
        code_q <= code_d;
        bits_q <= bits_d;
        err_q  <= err_d;
        stop_q <= stop_d;
      end
    end
  end

endmodule

@@ rtl/nec_ir_frame_checker.sv @@
// ----------------------------------------------------------------------------
// nec_ir_frame_checker
// NEC infrared frame checker: decodes a learned frame of pulse durations
// and reports a status and the 32-bit code on the frame's last duration.
// ----------------------------------------------------------------------------
// Takes one duration per cycle (1 transaction per clock sustained). Each
// duration is registered on entry, then decoded by a single 17-bit add and
// window compares, and the end-of-frame result is placed in an output
// register. Input stalls only when a finished result is still waiting in the
// output register and another frame end is ready to be decoded. Registers on
// the configuration port are always ready and should be written while no
// frame is in progress.
module nec_ir_frame_checker
  import nec_chk_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CodeW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [DurW-1:0]    duration_i,
  input  logic               frame_end_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic [CodeW-1:0]   decoded_code_o
);

  cfg_t cfg;

  logic            s1_valid_q;
  logic [DurW-1:0] s1_dur_q;
  logic            s1_end_q;
  logic            s1_go;

  status_e          res_status;
  logic [CodeW-1:0] res_code;

  logic             out_valid_q;
  status_e          out_status_q;
  logic [CodeW-1:0] out_code_q;

  nec_chk_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // a frame end needs a free output slot; other durations always proceed
  assign s1_go      = s1_valid_q && (!s1_end_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_dur_q <= duration_i;
      s1_end_q <= frame_end_i;
    end
  end

  nec_chk_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (s1_go),
    .duration_i  (s1_dur_q),
    .frame_end_i (s1_end_q),
    .cfg_i       (cfg),
    .status_o    (res_status),
    .code_o      (res_code)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_end_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_end_q) begin
      out_status_q <= res_status;
      out_code_q   <= res_code;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign decoded_code_o = out_code_q;

endmodule

@@ tb/nec_ir_frame_checker_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nec_ir_frame_checker_tb
// Self-checking bench for the NEC infrared frame checker. A short table of
// hand-picked durations comes first: leader edges, short frames, a lone final
// mark and timing errors. Random frames follow over several window and code
// settings: mostly well-formed frames, plus noise and broken leaders. A
// behavioral decoder predicts each verdict that the table does not give. Both
// handshake sides stall at random.
// ----------------------------------------------------------------------------
module nec_ir_frame_checker_tb;
  import nec_chk_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned NumPhases   = 6;
  localparam int unsigned QuietPhase  = 2;
  localparam int unsigned PhaseItems  = 230;
  localparam int unsigned PhaseFrames = 3;
  localparam int unsigned NumDir      = 27;
  localparam logic [SumW-1:0] SumMax  = 17'd131070;

  typedef struct packed {
    status_e          status;
    logic [CodeW-1:0] code;
  } frame_verdict_t;

  typedef struct packed {
    logic [DurW-1:0]  dur;
    logic             last;
    logic             typed;
    status_e          status;
    logic [CodeW-1:0] code;
  } dir_row_t;

  // Rows with typed = 0 are checked against the decoder model only.
  localparam dir_row_t DirTab [NumDir] = '{
    '{16'd0,     1'b1, 1'b1, StLeader, 32'd0},  // shortest leader mark
    '{16'd65535, 1'b1, 1'b1, StLeader, 32'd0},  // saturated leader mark
    '{16'd8500,  1'b1, 1'b1, StLeader, 32'd0},  // frame ends inside leader
    '{16'd8499,  1'b1, 1'b1, StLeader, 32'd0},
    '{16'd9501,  1'b1, 1'b1, StLeader, 32'd0},
    '{16'd9500,  1'b0, 1'b0, StOk,     32'd0},
    '{16'd5000,  1'b1, 1'b1, StShort,  32'd0},  // good leader, no bits
    '{16'd9000,  1'b0, 1'b0, StOk,     32'd0},
    '{16'd3999,  1'b1, 1'b1, StLeader, 32'd0},
    '{16'd8500,  1'b0, 1'b0, StOk,     32'd0},
    '{16'd5001,  1'b1, 1'b1, StLeader, 32'd0},
    '{16'd9000,  1'b0, 1'b0, StOk,     32'd0},
    '{16'd4000,  1'b0, 1'b0, StOk,     32'd0},
    '{16'd560,   1'b0, 1'b0, StOk,     32'd0},
    '{16'd1690,  1'b0, 1'b0, StOk,     32'd0},  // one
    '{16'd560,   1'b0, 1'b0, StOk,     32'd0},
    '{16'd560,   1'b0, 1'b0, StOk,     32'd0},  // zero
    '{16'd2000,  1'b1, 1'b0, StOk,     32'd0},  // lone final mark, space of zero
    '{16'd9000,  1'b0, 1'b0, StOk,     32'd0},
    '{16'd4500,  1'b0, 1'b0, StOk,     32'd0},
    '{16'd560,   1'b0, 1'b0, StOk,     32'd0},
    '{16'd65535, 1'b1, 1'b1, StTiming, 32'd0},  // sum outside both windows
    '{16'd9000,  1'b0, 1'b0, StOk,     32'd0},
    '{16'd4500,  1'b0, 1'b0, StOk,     32'd0},
    '{16'd0,     1'b0, 1'b0, StOk,     32'd0},
    '{16'd0,     1'b0, 1'b0, StOk,     32'd0},  // zero sum: timing error
    '{16'd1000,  1'b1, 1'b1, StTiming, 32'd0}   // ignored after the error
  };

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CodeW-1:0]   cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [DurW-1:0]    duration_i;
  logic               frame_end_i;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [2:0]         status_o;
  logic [CodeW-1:0]   decoded_code_o;

  // decoder model state
  cfg_t                model_cfg;
  logic [PosW-1:0]     pos_q;
  logic [DurW-1:0]     mark_q;
  logic [CodeW-1:0]    bits_q;
  logic [BitCntW-1:0]  nbits_q;
  status_e             err_q;
  logic                stopped_q;

  frame_verdict_t  frame_verdicts_q[$];
  logic [DurW-1:0] frame_q[$];
  bit              quiet_q = 1'b0;
  int unsigned     mismatches      = 0;
  int unsigned     results_checked = 0;
  int unsigned     items_sent      = 0;
  int unsigned     frames_sent     = 0;
  int unsigned     cycle_count     = 0;

  nec_ir_frame_checker DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .duration_i     (duration_i),
    .frame_end_i    (frame_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .decoded_code_o (decoded_code_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("nec_ir_frame_checker_tb failed");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  // ---- decoder model ----

  function automatic void clear_frame_model();
    pos_q     = '0;
    mark_q    = '0;
    bits_q    = '0;
    nbits_q   = '0;
    err_q     = StOk;
    stopped_q = 1'b0;
  endfunction

  function automatic void check_lead(input logic [DurW-1:0] d, input logic [DurW-1:0] lo,
                                     input logic [DurW-1:0] hi);
    if (err_q == StOk && (d < lo || d > hi)) err_q = StLeader;
  endfunction

  function automatic void fold_pair(input logic [DurW-1:0] m, input logic [DurW-1:0] s);
    logic [SumW-1:0] sum;
    logic            is_zero;
    logic            is_one;
    sum     = {1'b0, m} + {1'b0, s};
    is_zero = (sum > model_cfg.zero_sum_low) && (sum < model_cfg.zero_sum_high);
    is_one  = (sum > model_cfg.one_sum_low) && (sum < model_cfg.one_sum_high);
    if (err_q != StOk || stopped_q) return;
    if (nbits_q >= CodeBitsTotal) begin
      // past bit 32: valid pairs dropped, first bad pair stops decoding quietly
      if (!is_zero && !is_one) stopped_q = 1'b1;
      return;
    end
    if (!is_zero) begin
      if (is_one) begin
        bits_q[nbits_q[4:0]] = 1'b1;
      end else begin
        err_q = StTiming;
        return;
      end
    end
    nbits_q++;
  endfunction

  // Returns 1 when the duration closes a frame, with the verdict in v.
  function automatic bit decode_duration(input logic [DurW-1:0] d, input logic last,
                                         output frame_verdict_t v);
    v = '0;
    if (pos_q == 0) begin
      check_lead(d, LeadMarkMin, LeadMarkMax);
      if (last) check_lead('0, LeadSpaceMin, LeadSpaceMax);
    end else if (pos_q == 1) begin
      check_lead(d, LeadSpaceMin, LeadSpaceMax);
    end else if (!pos_q[0]) begin
      mark_q = d;
      if (last) fold_pair(d, '0);
    end else begin
      fold_pair(mark_q, d);
    end
    if (pos_q < PosMax) pos_q++;
    if (!last) return 1'b0;
    if (err_q != StOk) v.status = err_q;
    else if (nbits_q < CodeBitsTotal) v.status = StShort;
    else if (bits_q != model_cfg.expected_code) v.status = StMismatch;
    else v.status = StOk;
    v.code = bits_q;
    clear_frame_model();
    return 1'b1;
  endfunction

  // ---- stimulus helpers ----

  function automatic logic [DurW-1:0] rand_duration();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return DurW'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic [DurW-1:0] near_edge(input int lo, input int hi);
    case ($urandom_range(4))
      0:       return DurW'(lo - 1);
      1:       return DurW'(lo);
      2:       return DurW'(hi);
      3:       return DurW'(hi + 1);
      default: return rand_duration();
    endcase
  endfunction

  // A sum strictly inside (lo, hi); any sum when the window is empty.
  function automatic logic [SumW-1:0] pick_sum(input logic [SumW-1:0] lo,
                                               input logic [SumW-1:0] hi);
    if (int'(hi) > int'(lo) + 1) return SumW'($urandom_range(int'(hi) - 1, int'(lo) + 1));
    return SumW'($urandom_range(SumMax));
  endfunction

  function automatic cfg_t phase_config(input int p);
    cfg_t c;
    c = CfgReset;
    case (p)
      0: c.expected_code = $urandom();
      1: begin  // overlapping windows
        c.expected_code = '1;
        c.zero_sum_low  = 17'd500;
        c.zero_sum_high = 17'd2000;
        c.one_sum_low   = 17'd1000;
        c.one_sum_high  = 17'd3000;
      end
      2: begin  // zero window holds every sum but 0 and 131070, one window empty
        c.expected_code = '0;
        c.zero_sum_low  = '0;
        c.zero_sum_high = SumMax;
        c.one_sum_low   = SumMax;
        c.one_sum_high  = '0;
      end
      3: begin
        c.expected_code = '1;
        c.zero_sum_low  = SumMax;
        c.zero_sum_high = SumMax;
        c.one_sum_low   = '0;
        c.one_sum_high  = SumMax;
      end
      4: begin
        c.expected_code = $urandom();
        c.zero_sum_low  = SumW'($urandom_range(1500)) | 17'd1;
        c.zero_sum_high = c.zero_sum_low + SumW'($urandom_range(2000));
        c.one_sum_low   = SumW'($urandom_range(3000, 1000)) | 17'd1;
        c.one_sum_high  = c.one_sum_low + SumW'($urandom_range(3000));
      end
      default: c = CfgReset;
    endcase
    return c;
  endfunction

  task automatic build_frame();
    int              roll;
    int              nbits;
    int              nextra;
    int              bad_at;
    int              len;
    bit              use_exp;
    logic            one_bit;
    logic [SumW-1:0] sum;
    logic [DurW-1:0] m;
    frame_q.delete();
    roll = $urandom_range(99);
    if (roll < 12) begin
      len = $urandom_range(8, 1);
      repeat (len) frame_q.push_back(rand_duration());
    end else if (roll < 22) begin
      frame_q.push_back(near_edge(LeadMarkMin, LeadMarkMax));
      frame_q.push_back(near_edge(LeadSpaceMin, LeadSpaceMax));
      len = $urandom_range(6);
      repeat (len) frame_q.push_back(rand_duration());
    end else begin
      frame_q.push_back(DurW'($urandom_range(LeadMarkMax, LeadMarkMin)));
      frame_q.push_back(DurW'($urandom_range(LeadSpaceMax, LeadSpaceMin)));
      roll    = $urandom_range(99);
      nbits   = (roll < 15) ? $urandom_range(31) : 32;
      nextra  = (roll >= 75) ? $urandom_range(40, 1) : 0;
      bad_at  = (roll >= 60 && roll < 75) ? $urandom_range(31) : -1;
      use_exp = $urandom_range(1);
      for (int i = 0; i < nbits + nextra; i++) begin
        if (i == bad_at || (i >= 32 && $urandom_range(99) < 10)) begin
          sum = ($urandom_range(1)) ? SumW'($urandom_range(SumMax)) : '0;
        end else begin
          one_bit = (use_exp && i < 32) ? model_cfg.expected_code[i] : 1'($urandom_range(1));
          sum = one_bit ? pick_sum(model_cfg.one_sum_low, model_cfg.one_sum_high)
                        : pick_sum(model_cfg.zero_sum_low, model_cfg.zero_sum_high);
        end
        m = DurW'($urandom_range((sum > 65535) ? 65535 : int'(sum),
                                 (sum > 65535) ? int'(sum) - 65535 : 0));
        frame_q.push_back(m);
        frame_q.push_back(DurW'(sum - {1'b0, m}));
      end
      if ($urandom_range(99) < 20) frame_q.push_back(rand_duration());  // lone final mark
    end
  endtask

  // ---- drivers ----

  task automatic send_duration(input logic [DurW-1:0] d, input logic last,
                               input logic use_typed, input frame_verdict_t typed);
    frame_verdict_t v;
    if (!quiet_q && $urandom_range(99) < 25) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 25);
    end
    in_valid_i  <= 1'b1;
    duration_i  <= d;
    frame_end_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (decode_duration(d, last, v)) begin
      frame_verdicts_q.push_back(use_typed ? typed : v);
      frames_sent++;
    end
  endtask

  task automatic write_config(input cfg_t c);
    cfg_reg_e         idx;
    logic [CodeW-1:0] data;
    logic [14:0]      pad;
    idx = idx.first();
    do begin
      // upper bits of the 17-bit registers carry junk now and then
      pad = $urandom_range(1) ? 15'($urandom()) : '0;
      case (idx)
        RegExpectedCode: data = c.expected_code;
        RegZeroSumLow:   data = {pad, c.zero_sum_low};
        RegZeroSumHigh:  data = {pad, c.zero_sum_high};
        RegOneSumLow:    data = {pad, c.one_sum_low};
        RegOneSumHigh:   data = {pad, c.one_sum_high};
        default:         data = '0;
      endcase
      if (!quiet_q && $urandom_range(99) < 25) begin
        cfg_valid_i <= 1'b0;
        do @(posedge clk_i); while ($urandom_range(99) < 25);
      end
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= data;
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx)
        RegExpectedCode: model_cfg.expected_code = data;
        RegZeroSumLow:   model_cfg.zero_sum_low  = data[SumW-1:0];
        RegZeroSumHigh:  model_cfg.zero_sum_high = data[SumW-1:0];
        RegOneSumLow:    model_cfg.one_sum_low   = data[SumW-1:0];
        RegOneSumHigh:   model_cfg.one_sum_high  = data[SumW-1:0];
        default: ;
      endcase
      idx = idx.next();
    end while (idx != idx.first());
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (frame_verdicts_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // ---- result side: random back-pressure and compare ----

  always @(posedge clk_i) begin
    frame_verdict_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_checked++;
      if (frame_verdicts_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result status %0d code %h",
                                status_o, decoded_code_o));
      end else begin
        want = frame_verdicts_q.pop_front();
        if (status_o !== want.status)
          flag_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
        if (decoded_code_o !== want.code)
          flag_mismatch($sformatf("code %h, expected %h", decoded_code_o, want.code));
      end
    end
    out_ready_i <= quiet_q || ($urandom_range(99) >= 25);
  end

  initial begin
    frame_verdict_t typed;
    int unsigned    phase_items;
    int unsigned    phase_frames;
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    duration_i  <= '0;
    frame_end_i <= 1'b0;
    model_cfg = CfgReset;
    clear_frame_model();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, reset register values
    for (int i = 0; i < NumDir; i++) begin
      typed.status = DirTab[i].status;
      typed.code   = DirTab[i].code;
      send_duration(DirTab[i].dur, DirTab[i].last, DirTab[i].typed, typed);
    end

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      quiet_q = (p == QuietPhase);
      write_config(phase_config(p));
      phase_items  = 0;
      phase_frames = 0;
      while (phase_items < PhaseItems || phase_frames < PhaseFrames) begin
        build_frame();
        foreach (frame_q[i]) send_duration(frame_q[i], i == frame_q.size() - 1, 1'b0, '0);
        phase_items += frame_q.size();
        phase_frames++;
      end
    end
    quiet_q = 1'b0;
    drain();

    if (frame_verdicts_q.size() != 0)
      flag_mismatch($sformatf("%0d frame results never arrived", frame_verdicts_q.size()));
    $display("sent %0d durations in %0d frames over %0d register settings",
             items_sent, frames_sent, NumPhases + 1);
    $display("checked %0d frame results, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("nec_ir_frame_checker_tb passed");
    end else begin
      $display("nec_ir_frame_checker_tb failed");
    end
    $finish;
  end

endmodule
